[design/mhpq_pkg.sv]
package mhpq_pkg;

    // Capacity of the queue, the widths that follow from it and the value width
    localparam int HEAP_DEPTH    = 1024;
    localparam int IDX_W         = $clog2(HEAP_DEPTH);
    localparam int CNT_W         = $clog2(HEAP_DEPTH + 1);
    localparam int ENTRY_COUNT_W = 11;
    localparam int VALUE_W       = 32;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [CNT_W-1:0]          t_count;
    typedef logic [IDX_W-1:0]          t_index;

    // Request codes carried on the action field
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic   push;
        logic   pop;
        t_value value;
        t_count count;
    } t_cell_cmd;

endpackage

[design/mhpq_if.sv]
// Request channel: one push or pop per word
interface mhpq_req_if;
    import mhpq_pkg::*;
    logic   valid;
    logic   ready;
    logic   action;
    t_value value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

// Result channel: one result word per request
interface mhpq_rsp_if;
    import mhpq_pkg::*;
    logic                     valid;
    logic                     ready;
    t_value                   popped_value;
    logic                     popped_valid;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     request_error;

    modport source (output valid, output popped_value, output popped_valid,
                    output entry_count, output request_error, input ready);
    modport sink   (input valid, input popped_value, input popped_valid,
                    input entry_count, input request_error, output ready);
endinterface

[design/mhpq_cell.sv]
module mhpq_cell
    import mhpq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_cmd i_cmd,
    input  t_index    i_index,
    input  t_value    i_left_value,
    input  logic      i_left_gt,
    input  t_value    i_right_value,
    output t_value    o_value,
    output logic      o_gt
);

    t_value r_value;
    t_value n_value;

    // Slot is greater than the new word when empty or holding a larger value
    assign o_gt = ({1'b0, i_index} >= (IDX_W + 1)'(i_cmd.count)) ||
                  (r_value > i_cmd.value);

    // Insert keeps the prefix that is not greater, takes the new word at the boundary
    // and shifts the rest up; a pop shifts everything down by one
    always_comb begin
        n_value = r_value;
        if (i_cmd.push && o_gt) begin
            n_value = i_left_gt ? i_left_value : i_cmd.value;
        end else if (i_cmd.pop) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

[design/min_heap_priority_queue_core.sv]
// Priority queue of up to HEAP_DEPTH signed 32-bit words, smallest out first.
// Entries are kept sorted in a row of cells, one word per cell, with the
// minimum in the first cell. A push compares the new word against every
// cell at once and each cell either holds, takes the new word or takes its
// left neighbor's word; a pop shifts every cell down from its right
// neighbor. The cells update and the result word is registered when a
// request is taken; a new request is taken in every cycle in which the
// result register is empty or being drained. A pop on an empty queue or a
// push on a full one returns request_error and leaves the contents alone.
module min_heap_priority_queue_core
    import mhpq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mhpq_req_if.sink   i_req,
    mhpq_rsp_if.source o_rsp
);

    t_count    r_count;
    t_count    n_count;
    logic      r_out_valid;
    t_value    r_popped_value;
    logic      r_popped_valid;
    logic      r_request_error;
    t_value    n_popped_value;
    logic      n_popped_valid;
    logic      n_request_error;
    logic      w_accept;
    t_cell_cmd w_cmd;

    t_value    w_value [HEAP_DEPTH];
    logic      w_gt    [HEAP_DEPTH];

    // Take a word when the result register is free or being drained
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    // Decode the request and check the bounds
    always_comb begin
        w_cmd.push      = 1'b0;
        w_cmd.pop       = 1'b0;
        w_cmd.value     = i_req.value;
        w_cmd.count     = r_count;
        n_count         = r_count;
        n_popped_value  = '0;
        n_popped_valid  = 1'b0;
        n_request_error = 1'b0;
        case (i_req.action)
            ACT_PUSH: begin
                if (r_count == t_count'(HEAP_DEPTH)) begin
                    n_request_error = 1'b1;
                end else begin
                    w_cmd.push = w_accept;
                    n_count    = r_count + t_count'(1);
                end
            end
            ACT_POP: begin
                if (r_count == '0) begin
                    n_request_error = 1'b1;
                end else begin
                    w_cmd.pop      = w_accept;
                    n_count        = r_count - t_count'(1);
                    n_popped_value = w_value[0];
                    n_popped_valid = 1'b1;
                end
            end
            default: begin
                n_request_error = 1'b1;
            end
        endcase
    end

    // Row of cells, each linked to both neighbors
    for (genvar g = 0; g < HEAP_DEPTH; g++) begin : g_cell
        t_value w_left_value;
        logic   w_left_gt;
        t_value w_right_value;

        if (g == 0) begin : g_first
            assign w_left_value = w_value[0];
            assign w_left_gt    = 1'b0;
        end else begin : g_mid
            assign w_left_value = w_value[g-1];
            assign w_left_gt    = w_gt[g-1];
        end

        if (g == HEAP_DEPTH - 1) begin : g_last
            assign w_right_value = w_value[g];
        end else begin : g_inner
            assign w_right_value = w_value[g+1];
        end

        mhpq_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_index       (t_index'(g)),
            .i_left_value  (w_left_value),
            .i_left_gt     (w_left_gt),
            .i_right_value (w_right_value),
            .o_value       (w_value[g]),
            .o_gt          (w_gt[g])
        );
    end

    // Hold the count and the result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped_value  <= n_popped_value;
            r_popped_valid  <= n_popped_valid;
            r_request_error <= n_request_error;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.popped_value  = r_popped_value;
    assign o_rsp.popped_valid  = r_popped_valid;
    assign o_rsp.entry_count   = ENTRY_COUNT_W'(r_count);
    assign o_rsp.request_error = r_request_error;

endmodule

[design/mhpq_checker.sv]
module mhpq_checker
    import mhpq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_ready,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  t_value                   i_popped_value,
    input  logic                     i_popped_valid,
    input  logic [ENTRY_COUNT_W-1:0] i_entry_count,
    input  logic                     i_request_error
);

    // No result word right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Never take a request while a result word is stalled
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("request taken over a stalled result");

    // A refused request never reports a popped word
    a_err_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_request_error) |-> (!i_popped_valid && i_popped_value == '0))
        else $error("refused request reports a popped word");

    // A successful push leaves at least one entry
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_request_error && !i_popped_valid) |-> (i_entry_count != '0))
        else $error("successful push with empty count");

    // A stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        ($stable(i_popped_value) && $stable(i_entry_count) && $stable(i_popped_valid)))
        else $error("stalled result word changed");

endmodule

bind min_heap_priority_queue_core mhpq_checker u_mhpq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_popped_value  (o_rsp.popped_value),
    .i_popped_valid  (o_rsp.popped_valid),
    .i_entry_count   (o_rsp.entry_count),
    .i_request_error (o_rsp.request_error)
);

[tb/tb_min_heap_priority_queue_core.sv]
`timescale 1ns / 1ps

module tb_min_heap_priority_queue_core;
    import mhpq_pkg::*;

    localparam t_value VAL_MAX        = 32'sh7FFF_FFFF;
    localparam t_value VAL_MIN        = 32'sh8000_0000;
    localparam int     QUIET_LIMIT    = 2000;
    localparam int     RX_HOLD_CYCLES = 300;

    // One result word as the block reports it
    typedef struct packed {
        t_value                   popped_value;
        logic                     popped_valid;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic                     request_error;
    } t_rsp_word;

    // One row of the directed table; want is used only when typed is set
    typedef struct packed {
        logic      act;
        t_value    val;
        logic      typed;
        t_rsp_word want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    mhpq_req_if req_ch ();
    mhpq_rsp_if rsp_ch ();

    min_heap_priority_queue_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Mirror of the heap and the words still owed by the block
    t_value      heap_mirror [HEAP_DEPTH];
    int unsigned heap_fill;
    t_rsp_word   pending_results [$];
    t_stim_row   directed_rows [$];

    // Word on offer: typed expectation travels with it
    logic      cur_typed;
    t_rsp_word cur_want;

    int mismatch_count;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_requests;
    int plan_count;
    int n_push;
    int n_pop;
    int n_refused;
    int peak_fill;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Apply one request to the mirror and return the word it should produce
    function automatic t_rsp_word heap_apply(logic act, t_value val);
        t_rsp_word   r;
        int unsigned pos;
        int unsigned up;
        int unsigned lc;
        int unsigned pick;
        t_value      tmp;
        r = '0;
        if (act == ACT_PUSH) begin
            if (heap_fill >= HEAP_DEPTH) begin
                r.request_error = 1'b1;
            end else begin
                pos = heap_fill;
                heap_mirror[pos] = val;
                heap_fill++;
                // sift up while the parent is strictly greater
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (heap_mirror[up] <= heap_mirror[pos]) break;
                    tmp = heap_mirror[up];
                    heap_mirror[up] = heap_mirror[pos];
                    heap_mirror[pos] = tmp;
                    pos = up;
                end
            end
        end else begin
            if (heap_fill == 0) begin
                r.request_error = 1'b1;
            end else begin
                r.popped_value = heap_mirror[0];
                r.popped_valid = 1'b1;
                heap_fill--;
                if (heap_fill > 0) begin
                    heap_mirror[0] = heap_mirror[heap_fill];
                    pos = 0;
                    // sift down toward the smaller child, right child on a tie
                    while (1) begin
                        lc = 2 * pos + 1;
                        if (lc >= heap_fill) break;
                        pick = lc;
                        if (lc + 1 < heap_fill && heap_mirror[lc + 1] <= heap_mirror[lc])
                            pick = lc + 1;
                        if (heap_mirror[pick] >= heap_mirror[pos]) break;
                        tmp = heap_mirror[pick];
                        heap_mirror[pick] = heap_mirror[pos];
                        heap_mirror[pos] = tmp;
                        pos = pick;
                    end
                end
            end
        end
        r.entry_count = heap_fill[ENTRY_COUNT_W-1:0];
        return r;
    endfunction

    // Mostly full-range values, with extremes and a narrow band for ties
    function automatic t_value pick_value();
        t_value v;
        case ($urandom_range(0, 9))
            0:       v = VAL_MAX;
            1:       v = VAL_MIN;
            2, 3:    v = t_value'($urandom_range(0, 8)) - 4;
            default: v = t_value'($urandom);
        endcase
        return v;
    endfunction

    task automatic log_mismatch(string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Offer one word, idling first at random; returns at the falling edge after acceptance
    task automatic send_word(logic act, t_value val, logic typed, t_rsp_word want);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.value  <= val;
        cur_typed     <= typed;
        cur_want      <= want;
        if (act == ACT_PUSH) begin
            if (plan_count < HEAP_DEPTH) plan_count++;
        end else if (plan_count > 0) begin
            plan_count--;
        end
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic run_mix(int items, int push_pct);
        logic act;
        for (int i = 0; i < items; i++) begin
            act = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
            send_word(act, pick_value(), 1'b0, '0);
        end
    endtask

    task automatic add_row(logic act, t_value val, logic typed, t_value pv, logic vld,
                           int cnt, logic err);
        t_stim_row row;
        row.act                = act;
        row.val                = val;
        row.typed              = typed;
        row.want.popped_value  = pv;
        row.want.popped_valid  = vld;
        row.want.entry_count   = ENTRY_COUNT_W'(cnt);
        row.want.request_error = err;
        directed_rows.push_back(row);
    endtask

    // Check result words, then record accepted requests
    always @(posedge i_clk) begin
        t_rsp_word w;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_results.size() == 0) begin
                    log_mismatch("result word with no request waiting");
                end else begin
                    w = pending_results.pop_front();
                    if (rsp_ch.popped_value !== w.popped_value)
                        log_mismatch($sformatf("popped_value %0d, want %0d",
                                               rsp_ch.popped_value, w.popped_value));
                    if (rsp_ch.popped_valid !== w.popped_valid)
                        log_mismatch($sformatf("popped_valid %b, want %b",
                                               rsp_ch.popped_valid, w.popped_valid));
                    if (rsp_ch.entry_count !== w.entry_count)
                        log_mismatch($sformatf("entry_count %0d, want %0d",
                                               rsp_ch.entry_count, w.entry_count));
                    if (rsp_ch.request_error !== w.request_error)
                        log_mismatch($sformatf("request_error %b, want %b",
                                               rsp_ch.request_error, w.request_error));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                w = heap_apply(req_ch.action, req_ch.value);
                if (req_ch.action == ACT_PUSH) n_push++;
                else n_pop++;
                if (w.request_error) n_refused++;
                if (heap_fill > peak_fill) peak_fill = heap_fill;
                if (cur_typed) w = cur_want;
                pending_results.push_back(w);
            end
        end
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        int quiet_cycles;
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no word moved for %0d cycles, %0d results owed",
                         quiet_cycles, pending_results.size());
                $display("tb_min_heap_priority_queue_core: FAIL");
                $finish;
            end
        end
    end

    // Result side: random stalls plus a long hold-off on request
    initial begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // Stimulus
    initial begin
        int refused_at_full;
        logic act;
        heap_fill      = 0;
        mismatch_count = 0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        hold_requests  = 0;
        plan_count     = 0;
        n_push         = 0;
        n_pop          = 0;
        n_refused      = 0;
        peak_fill      = 0;
        i_rst_n       <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.action <= ACT_PUSH;
        req_ch.value  <= '0;
        cur_typed     <= 1'b0;
        cur_want      <= '0;

        // Directed table: empty pops, extremes, ties, full drain
        add_row(ACT_POP,  VAL_MAX,         1, 0,       0, 0, 1);
        add_row(ACT_POP,  VAL_MIN,         1, 0,       0, 0, 1);
        add_row(ACT_PUSH, VAL_MAX,         1, 0,       0, 1, 0);
        add_row(ACT_PUSH, VAL_MIN,         1, 0,       0, 2, 0);
        add_row(ACT_PUSH, 0,               1, 0,       0, 3, 0);
        add_row(ACT_PUSH, -1,              1, 0,       0, 4, 0);
        add_row(ACT_PUSH, 0,               1, 0,       0, 5, 0);
        add_row(ACT_PUSH, 5,               1, 0,       0, 6, 0);
        add_row(ACT_PUSH, 5,               1, 0,       0, 7, 0);
        add_row(ACT_PUSH, 5,               1, 0,       0, 8, 0);
        add_row(ACT_POP,  32'sh5A5A_5A5A,  1, VAL_MIN, 1, 7, 0);
        add_row(ACT_POP,  VAL_MAX,         1, -1,      1, 6, 0);
        for (int i = 0; i < 5; i++)
            add_row(ACT_POP, t_value'(i), 0, 0, 0, 0, 0);
        add_row(ACT_POP,  VAL_MIN,         1, VAL_MAX, 1, 0, 0);
        add_row(ACT_POP,  -1,              1, 0,       0, 0, 1);
        add_row(ACT_PUSH, -7,              0, 0,       0, 0, 0);
        add_row(ACT_PUSH, 3,               0, 0,       0, 0, 0);
        add_row(ACT_PUSH, -7,              0, 0,       0, 0, 0);
        add_row(ACT_POP,  0,               0, 0,       0, 0, 0);

        // Reset
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].act, directed_rows[i].val,
                      directed_rows[i].typed, directed_rows[i].want);

        // No idling, with one long hold-off on the result side
        run_mix(60, 55);
        hold_requests++;
        run_mix(140, 55);

        // Sender idle most cycles
        tx_idle_pct = 78;
        run_mix(200, 50);

        // Pause until every owed result is back, then receiver stalls
        req_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
        tx_idle_pct  = 0;
        rx_stall_pct = 78;
        run_mix(200, 50);

        // Both sides idle a little; fill to capacity and push into the full heap
        tx_idle_pct     = 20;
        rx_stall_pct    = 20;
        refused_at_full = 0;
        while (!(plan_count == HEAP_DEPTH && refused_at_full >= 12)) begin
            act = ($urandom_range(0, 99) < 95) ? ACT_PUSH : ACT_POP;
            if (act == ACT_PUSH && plan_count == HEAP_DEPTH) refused_at_full++;
            send_word(act, pick_value(), 1'b0, '0);
        end

        // Pop-heavy stretch with no idling
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        run_mix(250, 20);

        // Drain
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run covered %0d pushes and %0d pops, %0d refused, peak fill %0d of %0d",
                 n_push, n_pop, n_refused, peak_fill, HEAP_DEPTH);
        $display("idle mixes: none, sender, receiver, both; %0d mismatches", mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_min_heap_priority_queue_core: PASS");
        end else begin
            $display("tb_min_heap_priority_queue_core: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
design/mhpq_pkg.sv
design/mhpq_if.sv
design/mhpq_cell.sv
design/min_heap_priority_queue_core.sv
design/mhpq_checker.sv
tb/tb_min_heap_priority_queue_core.sv
